FILE: rtl/core/qtd_pkg.sv
// shared types and constants for the quadtree leaf decoder
`default_nettype none

package qtd_pkg;

  // symbol codes on the input channel
  localparam logic [1:0] SYM_WHITE = 2'd0;
  localparam logic [1:0] SYM_BLACK = 2'd1;
  localparam logic [1:0] SYM_SPLIT = 2'd2;

  // largest supported image side log, bounded by the fixed field widths
  localparam int unsigned MAX_SIDE_LOG = 6;

  // field widths
  localparam int unsigned SYM_W   = 2;
  localparam int unsigned CFG_W   = 3;
  localparam int unsigned COORD_W = 6;
  localparam int unsigned DEPTH_W = 3;
  localparam logic [CFG_W-1:0] CFG_RESET = 3'd3;

  // classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_WHITE,
    OP_BLACK,
    OP_SPLIT
  } qtd_op_e;

  // queue head as seen by the back end
  typedef struct packed {
    logic    valid;
    qtd_op_e op;
  } qtd_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/qtd_front.sv
// front end: accepts symbols and classifies them into operations
`default_nettype none

module qtd_front import qtd_pkg::*; (
  input  wire logic [SYM_W-1:0] symbol_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output qtd_op_e               push_op_o
);

  logic known;

  // classify: the unused code is consumed and dropped
  always_comb begin
    known     = 1'b1;
    push_op_o = OP_WHITE;
    case (symbol_i)
      SYM_WHITE: push_op_o = OP_WHITE;
      SYM_BLACK: push_op_o = OP_BLACK;
      SYM_SPLIT: push_op_o = OP_SPLIT;
      default:   known     = 1'b0;
    endcase
  end

  // accept whenever the queue has room
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o && known;

endmodule

`default_nettype wire

FILE: rtl/core/qtd_queue.sv
// two-entry queue of classified operations between front and back
`default_nettype none

module qtd_queue import qtd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire qtd_op_e push_op_i,
  output logic         full_o,
  output qtd_req_t     head_o,
  input  wire logic    pop_i
);

  qtd_op_e     mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  assign full_o       = count_q[1];
  assign head_o.valid = (count_q != 2'd0);
  assign head_o.op    = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

FILE: rtl/core/qtd_back.sv
// back end: depth and z-order position tracking, leaf word register
`default_nettype none

module qtd_back import qtd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [CFG_W-1:0]   side_log_i,
  input  wire qtd_req_t           head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    is_black_o,
  output logic [COORD_W-1:0]      row_o,
  output logic [COORD_W-1:0]      col_o,
  output logic [CFG_W-1:0]        block_side_log_o,
  output logic                    tree_done_o
);

  localparam int unsigned PW = 2 * MAX_SIDE_LOG;
  localparam int unsigned ZW = MAX_SIDE_LOG + 8;

  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic               valid_q, valid_d;
  logic               black_q, black_d;
  logic [COORD_W-1:0] row_q, row_d;
  logic [COORD_W-1:0] col_q, col_d;
  logic [CFG_W-1:0]   bsl_q, bsl_d;
  logic               done_q, done_d;

  logic [CFG_W-1:0]        lim;
  logic [DEPTH_W-1:0]      depth_eff;
  logic [CFG_W-1:0]        s;
  logic [PW-1:0]           pos_next;
  logic [MAX_SIDE_LOG-1:0] zero_dig;
  logic [ZW-1:0]           zero_ext;
  logic [ZW-1:0]           zero_sh;
  logic [DEPTH_W-1:0]      climb;
  logic [DEPTH_W-1:0]      depth_new;
  logic [COORD_W-1:0]      row_c, col_c;
  logic                    is_leaf;
  logic                    out_free;

  // effective image size
  assign lim = (side_log_i > CFG_W'(MAX_SIDE_LOG)) ? CFG_W'(MAX_SIDE_LOG) : side_log_i;

  // leaf size at current depth
  assign depth_eff = (depth_q > lim) ? lim : depth_q;
  assign s         = lim - depth_eff;

  // deinterleave z-order position into row and column
  for (genvar i = 0; i < COORD_W; i++) begin : g_coord
    if (i < MAX_SIDE_LOG) begin : g_bit
      assign row_c[i] = pos_q[2*i+1];
      assign col_c[i] = pos_q[2*i];
    end else begin : g_pad
      assign row_c[i] = 1'b0;
      assign col_c[i] = 1'b0;
    end
  end

  // advance by leaf area and find finished sibling groups
  assign pos_next = pos_q + (PW'(1) << (2 * s));

  for (genvar i = 0; i < MAX_SIDE_LOG; i++) begin : g_zero
    assign zero_dig[i] = (pos_next[2*i+1:2*i] == 2'b00);
  end

  assign zero_ext = {8'hFF, zero_dig};
  assign zero_sh  = zero_ext >> s;

  always_comb begin
    logic run;
    run   = 1'b1;
    climb = '0;
    for (int j = 0; j < MAX_SIDE_LOG; j++) begin
      if (run && (j < int'(depth_eff)) && zero_sh[j]) begin
        climb = climb + DEPTH_W'(1);
      end else begin
        run = 1'b0;
      end
    end
  end

  assign depth_new = depth_eff - climb;

  // handshake with the queue: splits never wait on the output
  assign is_leaf  = (head_i.op != OP_SPLIT);
  assign out_free = !valid_q || out_ready_i;
  assign pop_o    = head_i.valid && (!is_leaf || out_free);

  // state and output word update
  always_comb begin
    depth_d = depth_q;
    pos_d   = pos_q;
    valid_d = valid_q && !out_ready_i;
    black_d = black_q;
    row_d   = row_q;
    col_d   = col_q;
    bsl_d   = bsl_q;
    done_d  = done_q;
    if (pop_o) begin
      case (head_i.op)
        OP_SPLIT: begin
          if (depth_q < lim) begin
            depth_d = depth_q + DEPTH_W'(1);
          end
        end
        OP_WHITE, OP_BLACK: begin
          valid_d = 1'b1;
          black_d = (head_i.op == OP_BLACK);
          row_d   = row_c;
          col_d   = col_c;
          bsl_d   = s;
          done_d  = (depth_new == '0);
          depth_d = depth_new;
          pos_d   = (depth_new == '0) ? '0 : pos_next;
        end
        default: begin
          depth_d = depth_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      depth_q <= depth_d;
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  // leaf word payload
  always_ff @(posedge clk_i) begin
    black_q <= black_d;
    row_q   <= row_d;
    col_q   <= col_d;
    bsl_q   <= bsl_d;
    done_q  <= done_d;
  end

  assign out_valid_o      = valid_q;
  assign is_black_o       = black_q;
  assign row_o            = row_q;
  assign col_o            = col_q;
  assign block_side_log_o = bsl_q;
  assign tree_done_o      = done_q;

endmodule

`default_nettype wire

FILE: rtl/core/quadtree_image_leaf_decoder.sv
// Quadtree leaf decoder: turns a preorder quadtree code into leaf blocks.
//
// Input channel: one 2-bit symbol per word (white leaf, black leaf, split),
// valid/ready handshake. The unused code is consumed and dropped.
// Output channel: one word per leaf with colour, top row, left column,
// log2 of the block side and a flag on the leaf that completes the image.
// Splits produce no output word.
// Configuration: cfg_we_i writes the 3-bit image side log, reset value 3,
// values above MAX_SIDE_LOG act as MAX_SIDE_LOG. Write only while idle.
// The leaf path runs through the operation queue and the output register.
// Throughput: one symbol per cycle while the output is not stalled; the
// depth and z-order update in the back end, including the trailing-digit
// climb, is combinational.
// A two-entry queue decouples the input from the back end; when the output
// is stalled, splits keep draining and the input takes up to two more
// words before in_ready_o drops.
// Reset: depth and position return to the tree root, the queue empties and
// the image side log returns to 3.
`default_nettype none

module quadtree_image_leaf_decoder import qtd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CFG_W-1:0]   cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [SYM_W-1:0]   symbol_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    is_black_o,
  output logic [COORD_W-1:0]      row_o,
  output logic [COORD_W-1:0]      col_o,
  output logic [CFG_W-1:0]        block_side_log_o,
  output logic                    tree_done_o
);

  logic [CFG_W-1:0] side_log_q;
  logic             q_full;
  logic             push;
  qtd_op_e          push_op;
  qtd_req_t         head;
  logic             pop;

  // image side log register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_log_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      side_log_q <= cfg_wdata_i;
    end
  end

  qtd_front u_front (
    .symbol_i   (symbol_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_op_o  (push_op)
  );

  qtd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .head_o    (head),
    .pop_i     (pop)
  );

  qtd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .side_log_i       (side_log_q),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .is_black_o       (is_black_o),
    .row_o            (row_o),
    .col_o            (col_o),
    .block_side_log_o (block_side_log_o),
    .tree_done_o      (tree_done_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/qtd_checker.sv
// port-level checks for the quadtree leaf decoder and their bind
`default_nettype none

module qtd_checker import qtd_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               cfg_we_i,
  input wire logic [CFG_W-1:0]   cfg_wdata_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [COORD_W-1:0] row_o,
  input wire logic [COORD_W-1:0] col_o,
  input wire logic [CFG_W-1:0]   block_side_log_o,
  input wire logic               tree_done_o
);

  logic [CFG_W-1:0] lim_q;
  logic [CFG_W-1:0] lim_d;

  // track the effective image size from the configuration port
  always_comb begin
    lim_d = lim_q;
    if (cfg_we_i) begin
      lim_d = (cfg_wdata_i > CFG_W'(MAX_SIDE_LOG)) ? CFG_W'(MAX_SIDE_LOG) : cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= (CFG_RESET > CFG_W'(MAX_SIDE_LOG)) ? CFG_W'(MAX_SIDE_LOG) : CFG_RESET;
    end else begin
      lim_q <= lim_d;
    end
  end

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // a stalled leaf keeps its position
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(row_o) && $stable(col_o))
    else $error("leaf position changed while stalled");

  // a leaf is never larger than the image
  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> block_side_log_o <= lim_q)
    else $error("leaf larger than the image");

  // a leaf covering the whole image ends the tree
  a_full_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (block_side_log_o == lim_q) |-> tree_done_o)
    else $error("full-image leaf without tree done");

endmodule

bind quadtree_image_leaf_decoder qtd_checker u_qtd_checker (.*);

`default_nettype wire
